// ===== rtl/core/mi4_pkg.sv =====
package mi4_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int OPW = 33;
  localparam int PW = 2 * OPW;
  localparam int PRW = 65;
  localparam int CW = 97;
  localparam int ACC_W = 136;

  localparam logic [1:0] SUB_P1 = 2'd0;
  localparam logic [1:0] SUB_P2 = 2'd1;
  localparam logic [1:0] SUB_L0 = 2'd2;
  localparam logic [1:0] SUB_L1 = 2'd3;

  localparam logic [1:0] SEL_P = 2'd0;
  localparam logic [1:0] SEL_Q = 2'd1;
  localparam logic [1:0] SEL_S = 2'd2;
  localparam logic [1:0] SEL_T = 2'd3;

  localparam logic [3:0] LAST_STEP_COF = 4'd11;
  localparam logic [3:0] LAST_STEP_DET = 4'd15;
  localparam logic [3:0] LAST_ELEM = 4'd15;

  typedef struct packed {
    logic [3:0] elem_index;
    logic signed [31:0] elem_value;
    logic go;
  } in_item_t;

  typedef struct packed {
    logic [3:0] out_index;
    logic signed [31:0] out_value;
    logic singular;
    logic last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COF,
    ST_DET,
    ST_CHECK,
    ST_SING,
    ST_DIV_GO,
    ST_DIV_WAIT
  } st_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_ABS,
    DV_LOAD,
    DV_ITER,
    DV_FIN
  } dv_st_t;

  // 3x3 minor position of each operand of an expansion term
  function automatic logic [3:0] term_idx(input logic [1:0] j, input logic [1:0] sel);
    logic [3:0] r;
    r = 4'd0;
    unique case (sel)
      SEL_P: r = (j == 2'd0) ? 4'd4 : 4'd3;
      SEL_Q: r = (j == 2'd2) ? 4'd7 : 4'd8;
      SEL_S: r = (j == 2'd2) ? 4'd4 : 4'd5;
      SEL_T: r = (j == 2'd0) ? 4'd7 : 4'd6;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // element address of minor position k for the cofactor at (r, c)
  function automatic logic [3:0] minor_addr(input logic [3:0] rc, input logic [3:0] k);
    logic [1:0] kr;
    logic [1:0] kc;
    logic [2:0] rr;
    logic [2:0] cc;
    kr = 2'd0;
    kc = 2'd0;
    unique case (k)
      4'd0: begin kr = 2'd0; kc = 2'd0; end
      4'd1: begin kr = 2'd0; kc = 2'd1; end
      4'd2: begin kr = 2'd0; kc = 2'd2; end
      4'd3: begin kr = 2'd1; kc = 2'd0; end
      4'd4: begin kr = 2'd1; kc = 2'd1; end
      4'd5: begin kr = 2'd1; kc = 2'd2; end
      4'd6: begin kr = 2'd2; kc = 2'd0; end
      4'd7: begin kr = 2'd2; kc = 2'd1; end
      4'd8: begin kr = 2'd2; kc = 2'd2; end
      default: begin kr = 2'd0; kc = 2'd0; end
    endcase
    rr = (kr >= rc[3:2]) ? {1'b0, kr} + 3'd1 : {1'b0, kr};
    cc = (kc >= rc[1:0]) ? {1'b0, kc} + 3'd1 : {1'b0, kc};
    return {rr[1:0], cc[1:0]};
  endfunction

endpackage

// ===== rtl/core/matrix_inverse_4x4.sv =====
// 4x4 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// input: an item transfers at a rising edge with start high and busy low.
//   each item writes elem_value to element elem_index (row*4 + column).
//   busy stays low during a plain load.
// an item with go set stores its element, then inverts the matrix:
//   all sixteen cofactors and the determinant are formed exactly on one
//   shared 33x33 multiplier, one partial product at a time;
//   each inverse element then goes through a restoring divider, one
//   element at a time.
// singular matrix: the stored elements are sent back unchanged, one per
//   cycle, with singular set.
// output: strobe is high for one cycle per result, sixteen results in
//   row-major order, last set on the sixteenth; the receiver cannot stall
// the inverse replaces the stored matrix. busy is high from go until the
//   last result is on the ports.
// reset clears the control state; matrix contents are undefined until
//   written.
module matrix_inverse_4x4 #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mi4_pkg::in_item_t   item,
  output logic                strobe,
  output mi4_pkg::out_item_t  result
);

  mi4_pkg::st_t state, state_next;

  logic signed [31:0]                 mat [16];
  logic signed [mi4_pkg::CW-1:0]      cof [16];
  logic signed [mi4_pkg::ACC_W-1:0]   acc;
  logic signed [mi4_pkg::ACC_W-1:0]   acc_upd;
  logic signed [mi4_pkg::ACC_W-1:0]   addend;
  logic signed [mi4_pkg::PRW-1:0]     pr;
  logic signed [mi4_pkg::OPW-1:0]     opa;
  logic signed [mi4_pkg::OPW-1:0]     opb;
  logic signed [mi4_pkg::OPW-1:0]     bval;
  logic signed [mi4_pkg::PW-1:0]      prod;
  logic signed [mi4_pkg::CW-1:0]      cv;
  logic [3:0]                         cidx;
  logic [3:0]                         step;
  logic [1:0]                         ph;
  logic [1:0]                         sub;
  logic [1:0]                         j;
  logic [3:0]                         addr_a;
  logic [3:0]                         addr_b;
  logic [3:0]                         raddr;
  logic [3:0]                         caddr;
  logic signed [31:0]                 rd;
  logic [6:0]                         shamt;
  logic                               sub_neg;
  logic                               div_start;
  logic                               div_done;
  logic signed [31:0]                 div_q;

  assign sub = step[1:0];
  assign j   = step[3:2];

  mi4_mul u_mul (
    .clk  (clk),
    .a    (opa),
    .b    (opb),
    .prod (prod)
  );

  mi4_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (cv),
    .den   (acc),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      mi4_pkg::ST_IDLE:
        if (start && item.go) state_next = mi4_pkg::ST_COF;
      mi4_pkg::ST_COF:
        if (ph == 2'd3 && step == mi4_pkg::LAST_STEP_COF && cidx == mi4_pkg::LAST_ELEM)
          state_next = mi4_pkg::ST_DET;
      mi4_pkg::ST_DET:
        if (ph == 2'd3 && step == mi4_pkg::LAST_STEP_DET) state_next = mi4_pkg::ST_CHECK;
      mi4_pkg::ST_CHECK:
        state_next = (acc == '0) ? mi4_pkg::ST_SING : mi4_pkg::ST_DIV_GO;
      mi4_pkg::ST_SING:
        if (cidx == mi4_pkg::LAST_ELEM) state_next = mi4_pkg::ST_IDLE;
      mi4_pkg::ST_DIV_GO:
        state_next = mi4_pkg::ST_DIV_WAIT;
      mi4_pkg::ST_DIV_WAIT:
        if (div_done)
          state_next = (cidx == mi4_pkg::LAST_ELEM) ? mi4_pkg::ST_IDLE : mi4_pkg::ST_DIV_GO;
      default:
        state_next = mi4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != mi4_pkg::ST_IDLE);
    div_start = (state == mi4_pkg::ST_DIV_GO);

    addr_a = 4'd0;
    addr_b = 4'd0;
    if (state == mi4_pkg::ST_DET) begin
      addr_a = {2'b00, step[3:2]};
    end else begin
      unique case (sub)
        mi4_pkg::SUB_P1: begin
          addr_a = mi4_pkg::minor_addr(cidx, mi4_pkg::term_idx(j, mi4_pkg::SEL_P));
          addr_b = mi4_pkg::minor_addr(cidx, mi4_pkg::term_idx(j, mi4_pkg::SEL_Q));
        end
        mi4_pkg::SUB_P2: begin
          addr_a = mi4_pkg::minor_addr(cidx, mi4_pkg::term_idx(j, mi4_pkg::SEL_S));
          addr_b = mi4_pkg::minor_addr(cidx, mi4_pkg::term_idx(j, mi4_pkg::SEL_T));
        end
        default: addr_a = mi4_pkg::minor_addr(cidx, {2'b00, j});
      endcase
    end

    priority if (state == mi4_pkg::ST_SING) raddr = cidx;
    else if (ph == 2'd0) raddr = addr_a;
    else raddr = addr_b;
    rd = mat[raddr];

    caddr = (state == mi4_pkg::ST_DET) ? {2'b00, step[3:2]} : {cidx[1:0], cidx[3:2]};
    cv = cof[caddr];

    bval    = '0;
    shamt   = 7'd0;
    sub_neg = 1'b0;
    if (state == mi4_pkg::ST_DET) begin
      unique case (step[1:0])
        2'd0: bval = {1'b0, cv[31:0]};
        2'd1: begin bval = {1'b0, cv[63:32]}; shamt = 7'd32; end
        2'd2: begin bval = cv[96:64]; shamt = 7'd64; end
        default: bval = '0;
      endcase
    end else begin
      sub_neg = (j == 2'd1) ^ cidx[2] ^ cidx[0];
      unique case (sub)
        mi4_pkg::SUB_L0: bval = {1'b0, pr[31:0]};
        mi4_pkg::SUB_L1: begin bval = pr[64:32]; shamt = 7'd32; end
        default:         bval = {rd[31], rd};
      endcase
    end

    addend  = {{(mi4_pkg::ACC_W - mi4_pkg::PW){prod[mi4_pkg::PW-1]}}, prod} <<< shamt;
    acc_upd = sub_neg ? acc - addend : acc + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mi4_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == mi4_pkg::ST_SING) || (state == mi4_pkg::ST_DIV_WAIT && div_done);
    end

    unique case (state)
      mi4_pkg::ST_IDLE: begin
        if (start) mat[item.elem_index] <= item.elem_value;
        cidx <= 4'd0;
        step <= 4'd0;
        ph   <= 2'd0;
        acc  <= '0;
      end
      mi4_pkg::ST_COF, mi4_pkg::ST_DET: begin
        ph <= ph + 2'd1;
        unique case (ph)
          2'd0: opa <= {rd[31], rd};
          2'd1: opb <= bval;
          2'd2: begin
          end
          default: begin
            if (state == mi4_pkg::ST_DET) begin
              acc  <= acc_upd;
              step <= step + 4'd1;
            end else begin
              unique case (sub)
                mi4_pkg::SUB_P1: pr <= prod[mi4_pkg::PRW-1:0];
                mi4_pkg::SUB_P2: pr <= pr - prod[mi4_pkg::PRW-1:0];
                default: begin
                  if (step != mi4_pkg::LAST_STEP_COF) acc <= acc_upd;
                end
              endcase
              if (step == mi4_pkg::LAST_STEP_COF) begin
                cof[cidx] <= acc_upd[mi4_pkg::CW-1:0];
                acc       <= '0;
                step      <= 4'd0;
                cidx      <= cidx + 4'd1;
              end else begin
                step <= step + 4'd1;
              end
            end
          end
        endcase
      end
      mi4_pkg::ST_SING: begin
        result.out_index <= cidx;
        result.out_value <= rd;
        result.singular  <= 1'b1;
        result.last      <= (cidx == mi4_pkg::LAST_ELEM);
        cidx             <= cidx + 4'd1;
      end
      mi4_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          result.out_index <= cidx;
          result.out_value <= div_q;
          result.singular  <= 1'b0;
          result.last      <= (cidx == mi4_pkg::LAST_ELEM);
          mat[cidx]        <= div_q;
          cidx             <= cidx + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/mi4_mul.sv =====
module mi4_mul (
  input  logic                             clk,
  input  logic signed [mi4_pkg::OPW-1:0]   a,
  input  logic signed [mi4_pkg::OPW-1:0]   b,
  output logic signed [mi4_pkg::PW-1:0]    prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== rtl/core/mi4_div.sv =====
module mi4_div #(
  parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [mi4_pkg::CW-1:0]      num,
  input  logic signed [mi4_pkg::ACC_W-1:0]   den,
  output logic                               done,
  output logic signed [31:0]                 quot
);

  localparam int SH = 2 * FRAC_BITS + 1;
  localparam int NW = mi4_pkg::CW + SH + 1;
  localparam int DW = mi4_pkg::ACC_W + 35;
  localparam int XW = (NW > DW) ? NW : DW;

  mi4_pkg::dv_st_t state, state_next;

  logic [mi4_pkg::CW-1:0]    n_abs;
  logic [mi4_pkg::ACC_W-1:0] d_abs;
  logic                      neg;
  logic [XW-1:0]             rem;
  logic [XW-1:0]             dsh;
  logic [32:0]               q;
  logic                      ovf;
  logic [5:0]                cnt;
  logic                      ge;

  assign ge = (rem >= dsh);

  always_comb begin
    state_next = state;
    unique case (state)
      mi4_pkg::DV_IDLE: if (start) state_next = mi4_pkg::DV_ABS;
      mi4_pkg::DV_ABS:  state_next = mi4_pkg::DV_LOAD;
      mi4_pkg::DV_LOAD: state_next = mi4_pkg::DV_ITER;
      mi4_pkg::DV_ITER: if (cnt == 6'd33) state_next = mi4_pkg::DV_FIN;
      mi4_pkg::DV_FIN:  state_next = mi4_pkg::DV_IDLE;
      default:          state_next = mi4_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    done = (state == mi4_pkg::DV_FIN);
    if (ovf) begin
      quot = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (neg) begin
      quot = (q > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-q);
    end else begin
      quot = (q > 33'h0_7fff_ffff) ? 32'sh7fff_ffff : q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mi4_pkg::DV_IDLE;
    end else begin
      state <= state_next;
    end
    unique case (state)
      mi4_pkg::DV_ABS: begin
        n_abs <= num[mi4_pkg::CW-1] ? mi4_pkg::CW'(-num) : mi4_pkg::CW'(num);
        d_abs <= den[mi4_pkg::ACC_W-1] ? mi4_pkg::ACC_W'(-den) : mi4_pkg::ACC_W'(den);
        neg   <= num[mi4_pkg::CW-1] ^ den[mi4_pkg::ACC_W-1];
      end
      mi4_pkg::DV_LOAD: begin
        rem <= (XW'(n_abs) << SH) + XW'(d_abs);
        dsh <= XW'(d_abs) << 34;
        cnt <= 6'd0;
        q   <= '0;
        ovf <= 1'b0;
      end
      mi4_pkg::DV_ITER: begin
        if (ge) rem <= rem - dsh;
        if (cnt == 6'd0) begin
          ovf <= ge;
        end else begin
          q <= {q[31:0], ge};
        end
        dsh <= dsh >> 1;
        cnt <= cnt + 6'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/matrix_inverse_4x4_tb.sv =====
`timescale 1ns / 100ps

module matrix_inverse_4x4_tb;

  localparam int FB = mi4_pkg::FRAC_BITS_DEF;
  localparam int N_ITEMS = 380;
  localparam int N_DIRECTED = 25;

  typedef struct {
    mi4_pkg::in_item_t item;
    bit typed;
    logic [31:0] diag;
  } stim_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  mi4_pkg::in_item_t item;
  logic strobe;
  mi4_pkg::out_item_t result;

  logic [31:0] mat_store [16];
  mi4_pkg::out_item_t inverse_q[$];
  int errors;
  int sent;

  matrix_inverse_4x4 uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .strobe(strobe),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (inverse_q.size() == 0) begin
        report("unexpected result", 32'(result.out_index), 32'd0);
      end else begin
        mi4_pkg::out_item_t e;
        e = inverse_q.pop_front();
        if (result.out_index !== e.out_index)
          report("out_index", 32'(result.out_index), 32'(e.out_index));
        if (result.out_value !== e.out_value) report("out_value", result.out_value, e.out_value);
        if (result.singular !== e.singular)
          report("singular", 32'(result.singular), 32'(e.singular));
        if (result.last !== e.last) report("last", 32'(result.last), 32'(e.last));
      end
    end
  end

  // signed cofactor of element (r, c), exact
  function automatic logic signed [191:0] cofactor(input int r, input int c);
    logic signed [191:0] x [9];
    logic signed [191:0] acc;
    int rs [3];
    int cs [3];
    int n;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != r) begin rs[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != c) begin cs[n] = k; n++; end
    for (int k = 0; k < 9; k++) x[k] = $signed(mat_store[rs[k / 3] * 4 + cs[k % 3]]);
    acc = x[0] * (x[4] * x[8] - x[5] * x[7]) - x[1] * (x[3] * x[8] - x[5] * x[6])
        + x[2] * (x[3] * x[7] - x[4] * x[6]);
    if (((r + c) & 1) != 0) acc = -acc;
    return acc;
  endfunction

  // num / den in fixed point, rounded half away from zero, saturated
  function automatic logic [31:0] fixed_quot(input logic signed [191:0] num,
                                             input logic signed [191:0] den);
    logic [191:0] n;
    logic [191:0] d;
    logic [191:0] q;
    bit neg;
    neg = num[191] ^ den[191];
    n = num[191] ? -num : num;
    d = den[191] ? -den : den;
    q = ((n << (2 * FB + 1)) + d) / (d << 1);
    if (neg) return (q > 192'h80000000) ? 32'h80000000 : -q[31:0];
    return (q > 192'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
  endfunction

  // store the element; on go, queue the sixteen expected results
  task automatic predict_inverse(input mi4_pkg::in_item_t it, input bit typed,
                                 input logic [31:0] diag);
    logic signed [191:0] cof [16];
    logic signed [191:0] det;
    logic [31:0] res [16];
    bit sing;
    mi4_pkg::out_item_t o;
    mat_store[it.elem_index] = it.elem_value;
    if (!it.go) return;
    det = '0;
    for (int k = 0; k < 16; k++) cof[k] = cofactor(k >> 2, k & 3);
    for (int k = 0; k < 4; k++) det += $signed(mat_store[k]) * cof[k];
    sing = (det == 0);
    for (int k = 0; k < 16; k++) begin
      if (sing) res[k] = mat_store[k];
      else res[k] = fixed_quot(cof[(k & 3) * 4 + (k >> 2)], det);
    end
    if (!sing) for (int k = 0; k < 16; k++) mat_store[k] = res[k];
    for (int k = 0; k < 16; k++) begin
      o.out_index = 4'(k);
      o.out_value = typed ? ((k % 5 == 0) ? diag : 32'h0) : res[k];
      o.singular = sing;
      o.last = (k == 15);
      inverse_q.push_back(o);
    end
  endtask

  task automatic send_elem(input mi4_pkg::in_item_t it, input bit typed,
                           input logic [31:0] diag);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_inverse(it, typed, diag);
    sent++;
  endtask

  task automatic maybe_idle();
    if (sent >= 150 && sent < 250) return;
    if ($urandom_range(99) < 21) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_value(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(524288)) - 262144;
      default: return $signed($urandom_range(131072)) - 65536;
    endcase
  endfunction

  initial begin
    stim_row_t dir [N_DIRECTED];
    mi4_pkg::in_item_t it;
    logic [31:0] row_vals [16];
    int kind;
    int pick;

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    errors = 0;
    sent = 0;
    for (int k = 0; k < 16; k++) mat_store[k] = '0;

    // identity, then diagonal scalings, then a zero on the diagonal
    for (int k = 0; k < 16; k++) begin
      dir[k].item = '{elem_index: 4'(k), elem_value: (k % 5 == 0) ? 32'h10000 : 32'h0,
                      go: (k == 15)};
      dir[k].typed = (k == 15);
      dir[k].diag = 32'h10000;
    end
    for (int k = 0; k < 4; k++) begin
      dir[16 + k].item = '{elem_index: 4'(k * 5), elem_value: 32'h20000, go: (k == 3)};
      dir[16 + k].typed = (k == 3);
      dir[16 + k].diag = 32'h8000;
      dir[20 + k].item = '{elem_index: 4'(k * 5), elem_value: 32'h80000000, go: (k == 3)};
      dir[20 + k].typed = (k == 3);
      dir[20 + k].diag = 32'hFFFFFFFE;
    end
    dir[24].item = '{elem_index: 4'd5, elem_value: 32'h0, go: 1'b1};
    dir[24].typed = 1'b0;
    dir[24].diag = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir[i]) begin
      send_elem(dir[i].item, dir[i].typed, dir[i].diag);
      maybe_idle();
    end

    // hold off until every queued result has come
    start <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);

    while (sent < N_ITEMS) begin
      if ($urandom_range(99) < 70) begin
        kind = $urandom_range(9) < 2 ? 0 : ($urandom_range(1) ? 1 : 2);
        for (int k = 0; k < 16; k++) row_vals[k] = rand_value(kind);
        pick = $urandom_range(9);
        if (pick == 0) begin
          for (int c = 0; c < 4; c++) row_vals[12 + c] = row_vals[c];
        end else if (pick == 1) begin
          for (int r = 0; r < 4; r++) row_vals[r * 4 + 3] = row_vals[r * 4 + 1];
        end else if (pick == 2) begin
          for (int c = 0; c < 4; c++) row_vals[4 + c] = '0;
        end
        for (int k = 0; k < 16; k++) begin
          it.elem_index = 4'(k);
          it.elem_value = row_vals[k];
          it.go = (k == 15);
          send_elem(it, 1'b0, '0);
          maybe_idle();
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          it.elem_index = 4'($urandom_range(15));
          it.elem_value = rand_value($urandom_range(2));
          it.go = ($urandom_range(7) == 0);
          send_elem(it, 1'b0, '0);
          maybe_idle();
        end
      end
    end
    start <= 1'b0;

    while (inverse_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
